@@ sv/escb_pkg.sv @@
// ----------------------------------------------------------------------------
// escb_pkg
// Shared types and constants of the escaped frame command bridge.
// ----------------------------------------------------------------------------
`default_nettype none

package escb_pkg;

    // Framing bytes.
    localparam logic [7:0] OPEN_MARK  = 8'h7B;
    localparam logic [7:0] CLOSE_MARK = 8'h7D;
    localparam logic [7:0] ESC_MARK   = 8'h7E;
    localparam logic [7:0] ESC_FLIP   = 8'h20;

    // Command codes.
    localparam logic [7:0] CMD_PIN_SET   = 8'h01;
    localparam logic [7:0] CMD_PIN_CLEAR = 8'h02;
    localparam logic [7:0] CMD_SPI_ONE   = 8'hE0;
    localparam logic [7:0] CMD_SPI_RATE  = 8'hE1;
    localparam logic [7:0] CMD_SPI_TWO   = 8'hE2;
    localparam logic [7:0] CMD_UART_DIV  = 8'hE3;
    localparam logic [7:0] CMD_ABOUT     = 8'hFF;

    // Answer bytes.
    localparam logic [7:0] STATUS_OK    = 8'h00;
    localparam logic [7:0] STATUS_ERROR = 8'hFF;
    localparam logic [7:0] ABOUT_CHAR_O = 8'h4F;
    localparam logic [7:0] ABOUT_CHAR_K = 8'h4B;

    // Bits forced into SPI control word one, and the rate field mask.
    localparam logic [7:0] SPI_ONE_FORCE = 8'h90;
    localparam logic [7:0] SPI_RATE_MASK = 8'h7F;

    // Settings after reset.
    localparam logic [3:0] PINS_RESET     = 4'h9;
    localparam logic [7:0] SPI_ONE_RESET  = 8'hDC;
    localparam logic [7:0] SPI_TWO_RESET  = 8'h00;
    localparam logic [6:0] SPI_RATE_RESET = 7'h72;
    localparam logic [7:0] UART_DIV_RESET = 8'd11;

    // Frame length counter width; covers a frame capacity of up to 31 bytes.
    localparam int LEN_W = 5;

    // Depth of the job queue between front and back.
    localparam int JOBQ_DEPTH = 2;

    typedef enum logic [1:0] {
        RX_IDLE   = 2'd0,
        RX_ACTIVE = 2'd1,
        RX_ESC    = 2'd2
    } rx_mode_t;

    typedef enum logic [1:0] {
        JOB_PLAIN = 2'd0,
        JOB_ABOUT = 2'd1,
        JOB_ECHO  = 2'd2
    } job_kind_t;

    typedef enum logic [2:0] {
        BE_IDLE   = 3'd0,
        BE_OPEN   = 3'd1,
        BE_STATUS = 3'd2,
        BE_OK_O   = 3'd3,
        BE_OK_K   = 3'd4,
        BE_FETCH  = 3'd5,
        BE_ECHO   = 3'd6,
        BE_CLOSE  = 3'd7
    } be_state_t;

    // One response to send, with the settings as they stand after its command.
    typedef struct packed {
        job_kind_t        kind;
        logic [7:0]       status;
        logic [LEN_W-1:0] len;
        logic [3:0]       pins;
        logic [7:0]       spi_one;
        logic [7:0]       spi_two;
        logic [6:0]       spi_rate;
        logic [7:0]       uart_div;
    } job_t;

endpackage

`default_nettype wire

@@ sv/escaped_frame_command_bridge_top.sv @@
// ----------------------------------------------------------------------------
// escaped_frame_command_bridge_top
// Byte-stuffed command frame receiver with escaped response frame output.
//
// Input: line bytes are written like a queue (push/full); one transfer per
// cycle while full is low. Frames open with '{' and close with '}', and 0x7E
// flips bit 5 of the byte after it. Frame bytes fill a FRAME_CAPACITY buffer.
// Output: response bytes are read like a queue (empty/pop), one transfer per
// cycle at best; frame_last marks the closing brace, and the settings ports
// carry the values left by the command that caused the response.
// A closing '}' queues a job; the transmit back takes it in its idle state
// and then writes the opening '{' to the output register. An escaped byte
// goes out as 0x7E and then flipped; each echoed frame byte passes a fetch
// state for the buffer read. A two-entry job queue lets the receive side keep
// taking bytes while a response drains, except while an echo response is
// outstanding (the buffer is being read back) or two jobs are queued.
// Reset puts the receiver outside a frame, empties queue and output, and
// restores the default pin and SPI/UART settings. A stalled reader only
// holds back the transmit side until the job queue fills.
// ----------------------------------------------------------------------------
`default_nettype none

module escaped_frame_command_bridge_top #(
    parameter int FRAME_CAPACITY = 16
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] line_byte_in,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      line_byte_out,
    output logic            frame_last,
    output logic [3:0]      pin_outputs,
    output logic [7:0]      spi_control_one,
    output logic [7:0]      spi_control_two,
    output logic [6:0]      spi_rate,
    output logic [7:0]      uart_divisor
);
    import escb_pkg::*;

    localparam int ADDR_W = $clog2(FRAME_CAPACITY);

    job_t              fe_job;
    job_t              q_job;
    logic              job_push;
    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              echo_done;
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data;

    escb_fe #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_fe (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .full        (full),
        .line_byte_in(line_byte_in),
        .job         (fe_job),
        .job_push    (job_push),
        .q_full      (q_full),
        .echo_done   (echo_done),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data)
    );

    escb_q u_q (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr     (job_push),
        .wr_job (fe_job),
        .q_full (q_full),
        .q_empty(q_empty),
        .rd     (q_pop),
        .rd_job (q_job)
    );

    escb_be #(
        .FRAME_CAPACITY(FRAME_CAPACITY)
    ) u_be (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_job          (q_job),
        .q_empty        (q_empty),
        .q_pop          (q_pop),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .echo_done      (echo_done),
        .pop            (pop),
        .empty          (empty),
        .line_byte_out  (line_byte_out),
        .frame_last     (frame_last),
        .pin_outputs    (pin_outputs),
        .spi_control_one(spi_control_one),
        .spi_control_two(spi_control_two),
        .spi_rate       (spi_rate),
        .uart_divisor   (uart_divisor)
    );

    // A full job queue must stall the line input.
    assert property (@(posedge clk) disable iff (!rst_n) q_full |-> full)
        else $error("job queue full while input not stalled");

    // Finishing an echo response leaves its closing brace in the output register.
    assert property (@(posedge clk) disable iff (!rst_n)
        echo_done |=> (!empty && frame_last && line_byte_out == CLOSE_MARK))
        else $error("echo response did not end with a closing brace");

    // Jobs are never pushed into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> !q_full)
        else $error("job pushed into full queue");

endmodule

`default_nettype wire

@@ sv/escb_fe.sv @@
// ----------------------------------------------------------------------------
// escb_fe
// Receive front: unframes and unescapes line bytes, fills the frame buffer,
// decodes the command on the closing brace and queues a response job.
// ----------------------------------------------------------------------------
`default_nettype none

module escb_fe #(
    parameter int FRAME_CAPACITY = 16,
    localparam int ADDR_W = $clog2(FRAME_CAPACITY)
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        line_byte_in,
    output escb_pkg::job_t         job,
    output logic                   job_push,
    input  wire logic              q_full,
    input  wire logic              echo_done,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic [7:0]             rd_data
);
    import escb_pkg::*;

    logic [7:0] frame_mem [FRAME_CAPACITY];

    rx_mode_t         rx_reg, rx_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [7:0]       cmd_reg, cmd_next;
    logic [7:0]       arg_reg, arg_next;
    logic             echo_out_reg, echo_out_next;
    logic [3:0]       pins_reg;
    logic [7:0]       spi_one_reg;
    logic [7:0]       spi_two_reg;
    logic [6:0]       spi_rate_reg;
    logic [7:0]       uart_div_reg;

    logic       accept;
    logic       wr_en;
    logic [7:0] wr_byte;
    logic [7:0] stored_byte;
    logic       is_open, is_close, is_esc;
    job_t       decoded;

    // While an echo response is outstanding the buffer is being read back.
    assign full   = echo_out_reg || q_full;
    assign accept = push && !full;

    assign is_open  = (line_byte_in == OPEN_MARK);
    assign is_close = (line_byte_in == CLOSE_MARK);
    assign is_esc   = (line_byte_in == ESC_MARK);

    // Next receive mode.
    always_comb
    begin
        rx_next = rx_reg;
        if (accept)
        begin
            case (rx_reg)
                RX_ESC:
                begin
                    rx_next = RX_ACTIVE;
                end
                RX_ACTIVE:
                begin
                    if (is_esc)
                    begin
                        rx_next = RX_ESC;
                    end
                    else if (is_close)
                    begin
                        rx_next = RX_IDLE;
                    end
                end
                default:
                begin
                    rx_next = is_open ? RX_ACTIVE : RX_IDLE;
                end
            endcase
        end
    end

    // Buffer fill and job hand-off.
    always_comb
    begin
        len_next    = len_reg;
        wr_en       = 1'b0;
        stored_byte = 8'h00;
        job_push    = 1'b0;
        if (accept)
        begin
            case (rx_reg)
                RX_ESC:
                begin
                    wr_en       = 1'b1;
                    stored_byte = line_byte_in ^ ESC_FLIP;
                end
                RX_ACTIVE:
                begin
                    if (is_open)
                    begin
                        len_next = '0;
                    end
                    else if (is_close)
                    begin
                        job_push = 1'b1;
                    end
                    else if (!is_esc)
                    begin
                        wr_en       = 1'b1;
                        stored_byte = line_byte_in;
                    end
                end
                default:
                begin
                    if (is_open)
                    begin
                        len_next = '0;
                    end
                end
            endcase
        end
        // Bytes past the buffer capacity are dropped.
        if (len_reg >= LEN_W'(FRAME_CAPACITY))
        begin
            wr_en = 1'b0;
        end
        if (wr_en)
        begin
            len_next = len_reg + LEN_W'(1);
        end
        wr_byte  = stored_byte;
        cmd_next = (wr_en && len_reg == LEN_W'(0)) ? stored_byte : cmd_reg;
        arg_next = (wr_en && len_reg == LEN_W'(1)) ? stored_byte : arg_reg;
    end

    // Command decode; the job carries the settings as they are after it.
    always_comb
    begin
        decoded.kind     = JOB_PLAIN;
        decoded.status   = STATUS_OK;
        decoded.len      = len_reg;
        decoded.pins     = pins_reg;
        decoded.spi_one  = spi_one_reg;
        decoded.spi_two  = spi_two_reg;
        decoded.spi_rate = spi_rate_reg;
        decoded.uart_div = uart_div_reg;
        if (len_reg == LEN_W'(2) && cmd_reg == CMD_PIN_SET)
        begin
            decoded.pins = pins_reg | arg_reg[3:0];
        end
        else if (len_reg == LEN_W'(2) && cmd_reg == CMD_PIN_CLEAR)
        begin
            decoded.pins = pins_reg & ~arg_reg[3:0];
        end
        else if (len_reg == LEN_W'(2) && cmd_reg == CMD_SPI_ONE)
        begin
            decoded.spi_one = arg_reg | SPI_ONE_FORCE;
        end
        else if (len_reg == LEN_W'(2) && cmd_reg == CMD_SPI_TWO)
        begin
            decoded.spi_two = arg_reg;
        end
        else if (len_reg == LEN_W'(2) && cmd_reg == CMD_SPI_RATE)
        begin
            decoded.spi_rate = arg_reg[6:0] & SPI_RATE_MASK[6:0];
        end
        else if (len_reg == LEN_W'(2) && cmd_reg == CMD_UART_DIV)
        begin
            if (arg_reg != 8'h00)
            begin
                decoded.uart_div = arg_reg;
            end
            else
            begin
                decoded.status = STATUS_ERROR;
            end
        end
        else if (len_reg == LEN_W'(1) && cmd_reg == CMD_ABOUT)
        begin
            decoded.kind = JOB_ABOUT;
        end
        else
        begin
            decoded.kind   = JOB_ECHO;
            decoded.status = STATUS_ERROR;
        end
    end

    assign job = decoded;

    always_comb
    begin
        echo_out_next = echo_out_reg;
        if (echo_done)
        begin
            echo_out_next = 1'b0;
        end
        if (job_push && decoded.kind == JOB_ECHO)
        begin
            echo_out_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rx_reg       <= RX_IDLE;
            len_reg      <= '0;
            echo_out_reg <= 1'b0;
            pins_reg     <= PINS_RESET;
            spi_one_reg  <= SPI_ONE_RESET;
            spi_two_reg  <= SPI_TWO_RESET;
            spi_rate_reg <= SPI_RATE_RESET;
            uart_div_reg <= UART_DIV_RESET;
        end
        else
        begin
            rx_reg       <= rx_next;
            len_reg      <= len_next;
            echo_out_reg <= echo_out_next;
            if (job_push)
            begin
                pins_reg     <= decoded.pins;
                spi_one_reg  <= decoded.spi_one;
                spi_two_reg  <= decoded.spi_two;
                spi_rate_reg <= decoded.spi_rate;
                uart_div_reg <= decoded.uart_div;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        arg_reg <= arg_next;
    end

    // Frame buffer: one write port here, one registered read port for the back.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_mem[len_reg[ADDR_W-1:0]] <= wr_byte;
        end
        rd_data <= frame_mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ sv/escb_q.sv @@
// ----------------------------------------------------------------------------
// escb_q
// Short job queue between the receive front and the transmit back.
// ----------------------------------------------------------------------------
`default_nettype none

module escb_q (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr,
    input  wire escb_pkg::job_t wr_job,
    output logic                q_full,
    output logic                q_empty,
    input  wire logic           rd,
    output escb_pkg::job_t      rd_job
);
    import escb_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);
    localparam int CNT_W = $clog2(JOBQ_DEPTH + 1);

    job_t             slots [JOBQ_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next;
    logic [PTR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign q_full  = (count_reg == CNT_W'(JOBQ_DEPTH));
    assign q_empty = (count_reg == '0);
    assign rd_job  = slots[head_reg];

    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (wr)
        begin
            tail_next = (tail_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : tail_reg + PTR_W'(1);
        end
        if (rd)
        begin
            head_next = (head_reg == PTR_W'(JOBQ_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
        end
        if (wr && !rd)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (rd && !wr)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            slots[tail_reg] <= wr_job;
        end
    end

endmodule

`default_nettype wire

@@ sv/escb_be.sv @@
// ----------------------------------------------------------------------------
// escb_be
// Transmit back: turns one queued job into an escaped response frame and
// presents it byte by byte through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module escb_be #(
    parameter int FRAME_CAPACITY = 16,
    localparam int ADDR_W = $clog2(FRAME_CAPACITY)
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire escb_pkg::job_t q_job,
    input  wire logic        q_empty,
    output logic             q_pop,
    output logic [ADDR_W-1:0] rd_addr,
    input  wire logic [7:0]  rd_data,
    output logic             echo_done,
    input  wire logic        pop,
    output logic             empty,
    output logic [7:0]       line_byte_out,
    output logic             frame_last,
    output logic [3:0]       pin_outputs,
    output logic [7:0]       spi_control_one,
    output logic [7:0]       spi_control_two,
    output logic [6:0]       spi_rate,
    output logic [7:0]       uart_divisor
);
    import escb_pkg::*;

    be_state_t        state_reg, state_next;
    job_t             job_reg;
    logic [LEN_W-1:0] idx_reg, idx_next;
    logic             esc_reg, esc_next;
    logic [7:0]       esc_byte_reg, esc_byte_next;
    logic             out_valid_reg;
    logic [7:0]       out_byte_reg;
    logic             out_last_reg;
    job_t             out_job_reg;

    logic       adv;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;
    logic       step;
    logic [7:0] data_byte;
    logic       data_state;

    // The output register can take a byte when it is empty or being drained.
    assign adv = !out_valid_reg || pop;

    assign rd_addr = idx_reg[ADDR_W-1:0];

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        if (step)
        begin
            case (state_reg)
                BE_IDLE:
                begin
                    state_next = BE_OPEN;
                end
                BE_OPEN:
                begin
                    state_next = BE_STATUS;
                end
                BE_STATUS:
                begin
                    if (job_reg.kind == JOB_ABOUT)
                    begin
                        state_next = BE_OK_O;
                    end
                    else if (job_reg.kind == JOB_ECHO && job_reg.len != '0)
                    begin
                        state_next = BE_FETCH;
                    end
                    else
                    begin
                        state_next = BE_CLOSE;
                    end
                end
                BE_OK_O:
                begin
                    state_next = BE_OK_K;
                end
                BE_OK_K:
                begin
                    state_next = BE_CLOSE;
                end
                BE_FETCH:
                begin
                    state_next = BE_ECHO;
                end
                BE_ECHO:
                begin
                    state_next = (idx_reg + LEN_W'(1) == job_reg.len) ? BE_CLOSE : BE_FETCH;
                end
                default:
                begin
                    state_next = BE_IDLE;
                end
            endcase
        end
    end

    // Outputs and datapath.
    always_comb
    begin
        case (state_reg)
            BE_STATUS: data_byte = job_reg.status;
            BE_OK_O:   data_byte = ABOUT_CHAR_O;
            BE_OK_K:   data_byte = ABOUT_CHAR_K;
            BE_ECHO:   data_byte = rd_data;
            default:   data_byte = 8'h00;
        endcase
        data_state = (state_reg == BE_STATUS) || (state_reg == BE_OK_O) ||
                     (state_reg == BE_OK_K) || (state_reg == BE_ECHO);

        emit          = 1'b0;
        emit_byte     = 8'h00;
        emit_last     = 1'b0;
        step          = 1'b0;
        q_pop         = 1'b0;
        esc_next      = esc_reg;
        esc_byte_next = esc_byte_reg;
        idx_next      = idx_reg;

        if (state_reg == BE_IDLE)
        begin
            if (!q_empty)
            begin
                q_pop = 1'b1;
                step  = 1'b1;
            end
        end
        else if (state_reg == BE_FETCH)
        begin
            step = 1'b1;
        end
        else if (adv)
        begin
            emit = 1'b1;
            if (state_reg == BE_OPEN)
            begin
                emit_byte = OPEN_MARK;
                step      = 1'b1;
            end
            else if (state_reg == BE_CLOSE)
            begin
                emit_byte = CLOSE_MARK;
                emit_last = 1'b1;
                step      = 1'b1;
            end
            else if (data_state)
            begin
                if (esc_reg)
                begin
                    emit_byte = esc_byte_reg;
                    esc_next  = 1'b0;
                    step      = 1'b1;
                end
                else if (data_byte == OPEN_MARK || data_byte == CLOSE_MARK ||
                         data_byte == ESC_MARK)
                begin
                    // Send the escape mark now and the flipped byte next.
                    emit_byte     = ESC_MARK;
                    esc_next      = 1'b1;
                    esc_byte_next = data_byte ^ ESC_FLIP;
                end
                else
                begin
                    emit_byte = data_byte;
                    step      = 1'b1;
                end
            end
        end

        if (step && state_reg == BE_STATUS)
        begin
            idx_next = '0;
        end
        else if (step && state_reg == BE_ECHO)
        begin
            idx_next = idx_reg + LEN_W'(1);
        end

        echo_done = step && (state_reg == BE_CLOSE) && (job_reg.kind == JOB_ECHO);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BE_IDLE;
            esc_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            esc_reg   <= esc_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        esc_byte_reg <= esc_byte_next;
        if (q_pop)
        begin
            job_reg <= q_job;
        end
        if (emit)
        begin
            out_byte_reg <= emit_byte;
            out_last_reg <= emit_last;
            out_job_reg  <= job_reg;
        end
    end

    assign empty           = !out_valid_reg;
    assign line_byte_out   = out_byte_reg;
    assign frame_last      = out_last_reg;
    assign pin_outputs     = out_job_reg.pins;
    assign spi_control_one = out_job_reg.spi_one;
    assign spi_control_two = out_job_reg.spi_two;
    assign spi_rate        = out_job_reg.spi_rate;
    assign uart_divisor    = out_job_reg.uart_div;

endmodule

`default_nettype wire
